>>> src/yuv_color_zone_counter_defines.svh
// assertion macros shared by the color zone counter modules
// no dependencies; included by files that carry concurrent checks
`ifndef YUV_COLOR_ZONE_COUNTER_DEFINES_SVH
`define YUV_COLOR_ZONE_COUNTER_DEFINES_SVH

// same-cycle implication, gated by the active-low reset
`define YCZC_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("yczc check failed");

// next-cycle implication, gated by the active-low reset
`define YCZC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("yczc check failed");

`endif

>>> src/yczc_pkg.sv
// types, codes and constants of the yuv color zone counter
// no dependencies; used by every other file of the block except the macro header
`timescale 1ns / 1ps

package yczc_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned POS_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned TALLY_W    = 25;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [PCT_W-1:0]   PCT_SCALE = PCT_W'(100);

  // floor(x/3) for 13-bit x as (x * 2731) >> 13
  localparam logic [11:0] THIRD_RECIP = 12'd2731;
  localparam int unsigned THIRD_SHIFT = 13;

  // reset values of the configuration registers
  localparam logic [15:0]      RST_LUMA_WIN = 16'd28230;
  localparam logic [15:0]      RST_U_WIN    = 16'd30800;
  localparam logic [15:0]      RST_V_WIN    = 16'd36968;
  localparam logic [DIM_W-1:0] RST_WIDTH    = DIM_W'(520);
  localparam logic [DIM_W-1:0] RST_HEIGHT   = DIM_W'(240);
  localparam logic [1:0]       RST_MODE     = 2'd3;
  localparam logic [PCT_W-1:0] RST_SAFE_PCT = PCT_W'(40);
  localparam logic [11:0]      RST_THIRD_W  = 12'(520 / 3);
  localparam logic [11:0]      RST_THIRD_H  = 12'(240 / 3);

  typedef enum logic [2:0] {
    REG_LUMA_WIN = 3'd0,
    REG_U_WIN    = 3'd1,
    REG_V_WIN    = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_MODE     = 3'd5,
    REG_SAFE_PCT = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    ZONE_NONE     = 2'd0,
    ZONE_LEFT     = 2'd1,
    ZONE_STRAIGHT = 2'd2,
    ZONE_RIGHT    = 2'd3
  } zone_e;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_e;

  typedef struct packed {
    logic [15:0]      luma_win;
    logic [15:0]      u_win;
    logic [15:0]      v_win;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [1:0]       mode;
    logic [PCT_W-1:0] safe_pct;
    logic [11:0]      third_w;
    logic [11:0]      third_h;
  } cfg_t;

  typedef struct packed {
    logic [7:0] chroma_u;
    logic [7:0] luma_first;
    logic [7:0] chroma_v;
    logic [7:0] luma_second;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic [TALLY_W-1:0] left_count;
    logic [TALLY_W-1:0] straight_count;
    logic [TALLY_W-1:0] right_count;
    logic [TALLY_W-1:0] match_total;
    logic [1:0]         steer;
  } res_t;

  typedef struct packed {
    zone_e zone_first;
    zone_e zone_second;
    logic  frame_end;
  } entry_t;

  typedef struct packed {
    logic [TALLY_W-1:0] left;
    logic [TALLY_W-1:0] straight;
    logic [TALLY_W-1:0] right;
    logic [TALLY_W-1:0] total;
  } tally_t;

endpackage

>>> src/yczc_if.sv
// valid/ready stream interfaces for pixel pairs and frame results
// depends on yczc_pkg
`timescale 1ns / 1ps

interface yczc_pix_if;
  import yczc_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yczc_res_if;
  import yczc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/yuv_color_zone_counter.sv
// yuv_color_zone_counter: one pixel pair (U, Y0, V, Y1) is taken per clock,
// sustained while the queue has room, with no gap between frames. Each pixel
// is tested against the configured Y/U/V windows and counted into left,
// straight or right zones; the pair that carries frame_end closes the frame and
// one result with the four counts and a steering code follows. The front end
// classifies a pair in the cycle it is taken, a four-entry queue separates it
// from the tally stage, and the result passes through the snapshot register and
// then the output register after the closing pair leaves the queue.
// The output register and the snapshot register let the next frame start while
// a result waits; input stalls only when the queue fills behind two pending
// results. The zone thirds derived from frame_width and frame_height are
// registered behind the write. No clearing pass after reset.
`timescale 1ns / 1ps

module yuv_color_zone_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yczc_pkg::ADDR_W-1:0]  paddr,
  input  logic [yczc_pkg::DATA_W-1:0]  pwdata,
  output logic [yczc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  yczc_pix_if.sink                     pix_i,
  yczc_res_if.source                   res_o
);
  import yczc_pkg::*;

  cfg_t   cfg;
  entry_t entry, head;
  logic   push, pop, full, empty;

  yczc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  yczc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pix     (pix_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  yczc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  yczc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .safe_pct_i (cfg.safe_pct),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .res        (res_o)
  );

endmodule

>>> src/yczc_regs.sv
// apb configuration registers plus registered frame thirds
// depends on yczc_pkg
`timescale 1ns / 1ps

module yczc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yczc_pkg::ADDR_W-1:0]  paddr,
  input  logic [yczc_pkg::DATA_W-1:0]  pwdata,
  output logic [yczc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output yczc_pkg::cfg_t               cfg_o
);
  import yczc_pkg::*;

  logic [15:0]      luma_win_q, u_win_q, v_win_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [1:0]       mode_q;
  logic [PCT_W-1:0] safe_pct_q;
  logic [11:0]      third_w_q, third_w_d, third_h_q, third_h_d;
  logic [24:0]      prod_w, prod_h;
  logic             wr_en;
  reg_e             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_win_q <= RST_LUMA_WIN;
      u_win_q    <= RST_U_WIN;
      v_win_q    <= RST_V_WIN;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      mode_q     <= RST_MODE;
      safe_pct_q <= RST_SAFE_PCT;
    end else if (wr_en) begin
      unique case (idx)
        REG_LUMA_WIN: luma_win_q <= pwdata[15:0];
        REG_U_WIN:    u_win_q    <= pwdata[15:0];
        REG_V_WIN:    v_win_q    <= pwdata[15:0];
        REG_WIDTH:    width_q    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:   height_q   <= pwdata[DIM_W-1:0];
        REG_MODE:     mode_q     <= pwdata[1:0];
        REG_SAFE_PCT: safe_pct_q <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // divide by three through the reciprocal; the thirds are registered behind the write
  assign prod_w    = 25'(width_q) * 25'(THIRD_RECIP);
  assign prod_h    = 25'(height_q) * 25'(THIRD_RECIP);
  assign third_w_d = prod_w[THIRD_SHIFT +: 12];
  assign third_h_d = prod_h[THIRD_SHIFT +: 12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      third_w_q <= RST_THIRD_W;
      third_h_q <= RST_THIRD_H;
    end else begin
      third_w_q <= third_w_d;
      third_h_q <= third_h_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_LUMA_WIN: prdata = DATA_W'(luma_win_q);
      REG_U_WIN:    prdata = DATA_W'(u_win_q);
      REG_V_WIN:    prdata = DATA_W'(v_win_q);
      REG_WIDTH:    prdata = DATA_W'(width_q);
      REG_HEIGHT:   prdata = DATA_W'(height_q);
      REG_MODE:     prdata = DATA_W'(mode_q);
      REG_SAFE_PCT: prdata = DATA_W'(safe_pct_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.luma_win = luma_win_q;
  assign cfg_o.u_win    = u_win_q;
  assign cfg_o.v_win    = v_win_q;
  assign cfg_o.width    = width_q;
  assign cfg_o.height   = height_q;
  assign cfg_o.mode     = mode_q;
  assign cfg_o.safe_pct = safe_pct_q;
  assign cfg_o.third_w  = third_w_q;
  assign cfg_o.third_h  = third_h_q;

endmodule

>>> src/yczc_front.sv
// front end: tracks pixel position and classifies both pixels of a pair into zones
// depends on yczc_pkg and yczc_pix_if
`timescale 1ns / 1ps

module yczc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  yczc_pkg::cfg_t   cfg_i,
  yczc_pix_if.sink         pix,
  input  logic             full_i,
  output logic             push_o,
  output yczc_pkg::entry_t entry_o
);
  import yczc_pkg::*;

  logic [POS_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [POS_W:0]   col_next;
  logic             row_wrap;

  function automatic logic in_win(input logic [15:0] win, input logic [7:0] val);
    return (val >= win[7:0]) && (val <= win[15:8]);
  endfunction

  function automatic zone_e classify(input cfg_t cfg, input logic [POS_W:0] x,
                                     input logic [ROW_W-1:0] y, input logic [7:0] luma,
                                     input logic [7:0] u, input logic [7:0] v);
    logic             rot;
    logic             skip;
    logic             match;
    logic [DIM_W-1:0] coord;
    logic [DIM_W-1:0] third;
    logic [DIM_W-1:0] two_third;
    zone_e            z;
    rot   = cfg.mode[0];
    skip  = cfg.mode[1] &&
            ((rot && (DIM_W'(x) < DIM_W'(cfg.width[DIM_W-1:1]))) ||
             (!rot && (DIM_W'(y) >= DIM_W'(cfg.height[DIM_W-1:1]))));
    match = in_win(cfg.luma_win, luma) && in_win(cfg.u_win, u) && in_win(cfg.v_win, v);
    coord = rot ? DIM_W'(y) : DIM_W'(x);
    third = rot ? DIM_W'(cfg.third_h) : DIM_W'(cfg.third_w);
    two_third = {third[DIM_W-2:0], 1'b0};
    if (skip || !match) begin
      z = ZONE_NONE;
    end else if (coord < third) begin
      z = ZONE_LEFT;
    end else if (coord < two_third) begin
      z = ZONE_STRAIGHT;
    end else begin
      z = ZONE_RIGHT;
    end
    return z;
  endfunction

  assign pix.ready = !full_i;
  assign push_o    = pix.valid && !full_i;

  assign entry_o.zone_first  = classify(cfg_i, {1'b0, col_q}, row_q, pix.data.luma_first,
                                        pix.data.chroma_u, pix.data.chroma_v);
  assign entry_o.zone_second = classify(cfg_i, {1'b0, col_q} + (POS_W + 1)'(1), row_q,
                                        pix.data.luma_second, pix.data.chroma_u,
                                        pix.data.chroma_v);
  assign entry_o.frame_end   = pix.data.frame_end;

  // a row ends at the configured width or at the position counter limit
  assign col_next = {1'b0, col_q} + (POS_W + 1)'(2);
  assign row_wrap = (DIM_W'(col_next) >= cfg_i.width) || col_next[POS_W];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (pix.data.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_wrap) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_next[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> src/yczc_queue.sv
// short fifo of classified pixel pairs between front and back end
// depends on yczc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "yuv_color_zone_counter_defines.svh"

module yczc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  yczc_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output yczc_pkg::entry_t head_o
);
  import yczc_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QAW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `YCZC_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= QCNT_W'(QDEPTH))
  `YCZC_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, pop_i, !empty_o)
  `YCZC_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + QCNT_W'(1))

endmodule

>>> src/yczc_back.sv
// back end: saturating zone tallies, frame snapshot and steering decision
// depends on yczc_pkg, yczc_res_if and the assertion macro header
`timescale 1ns / 1ps
`include "yuv_color_zone_counter_defines.svh"

module yczc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [yczc_pkg::PCT_W-1:0]   safe_pct_i,
  input  logic                         empty_i,
  input  yczc_pkg::entry_t             head_i,
  output logic                         pop_o,
  yczc_res_if.source                   res
);
  import yczc_pkg::*;

  tally_t  tally_q, tally_d, tally_sum;
  tally_t  snap_q;
  logic    snap_valid_q, snap_valid_d;
  logic    snap_move;
  res_t    out_q;
  logic    out_valid_q, out_valid_d;
  logic [1:0] inc_l, inc_s, inc_r, inc_t;
  logic [31:0] pct_straight, pct_total;
  steer_e  steer;

  function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] a,
                                                 input logic [1:0] b);
    logic [TALLY_W:0] s;
    s = {1'b0, a} + (TALLY_W + 1)'(b);
    return (s > {1'b0, TALLY_MAX}) ? TALLY_MAX : s[TALLY_W-1:0];
  endfunction

  assign inc_l = 2'(head_i.zone_first == ZONE_LEFT) + 2'(head_i.zone_second == ZONE_LEFT);
  assign inc_s = 2'(head_i.zone_first == ZONE_STRAIGHT) +
                 2'(head_i.zone_second == ZONE_STRAIGHT);
  assign inc_r = 2'(head_i.zone_first == ZONE_RIGHT) + 2'(head_i.zone_second == ZONE_RIGHT);
  assign inc_t = 2'(head_i.zone_first != ZONE_NONE) + 2'(head_i.zone_second != ZONE_NONE);

  assign tally_sum.left     = sat_add(tally_q.left, inc_l);
  assign tally_sum.straight = sat_add(tally_q.straight, inc_s);
  assign tally_sum.right    = sat_add(tally_q.right, inc_r);
  assign tally_sum.total    = sat_add(tally_q.total, inc_t);

  assign snap_move = snap_valid_q && (!out_valid_q || res.ready);
  // an end-of-frame beat needs a free snapshot slot
  assign pop_o = !empty_i && (!head_i.frame_end || !snap_valid_q || snap_move);

  always_comb begin
    tally_d      = tally_q;
    snap_valid_d = snap_valid_q && !snap_move;
    if (pop_o) begin
      if (head_i.frame_end) begin
        tally_d      = '0;
        snap_valid_d = 1'b1;
      end else begin
        tally_d = tally_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      tally_q      <= tally_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.frame_end) begin
      snap_q <= tally_sum;
    end
  end

  // straight share test: 100*straight < safe_pct*total
  assign pct_straight = 32'(snap_q.straight) * 32'(PCT_SCALE);
  assign pct_total    = 32'(snap_q.total) * 32'(safe_pct_i);

  always_comb begin
    priority if ((snap_q.total == '0) || (pct_straight < pct_total)) begin
      steer = STEER_STRAIGHT;
    end else if ((snap_q.left < snap_q.straight) && (snap_q.left < snap_q.right)) begin
      steer = STEER_LEFT;
    end else begin
      steer = STEER_RIGHT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (snap_move) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_move) begin
      out_q.left_count     <= snap_q.left;
      out_q.straight_count <= snap_q.straight;
      out_q.right_count    <= snap_q.right;
      out_q.match_total    <= snap_q.total;
      out_q.steer          <= steer;
    end
  end

  assign res.valid = out_valid_q;
  assign res.data  = out_q;

  `YCZC_ASSERT_NOW(a_left_le_total, clk_i, rst_ni, 1'b1, tally_q.left <= tally_q.total)
  `YCZC_ASSERT_NEXT(a_frame_clears, clk_i, rst_ni, pop_o && head_i.frame_end, tally_q.total == '0)
  `YCZC_ASSERT_NEXT(a_snap_kept, clk_i, rst_ni, snap_valid_q && !snap_move, snap_valid_q)

endmodule

>>> verif/tb_yuv_color_zone_counter.sv
// self-checking testbench for yuv_color_zone_counter: directed plan then random frames
// depends on yczc_pkg and the stream interfaces in yczc_if; drives the block over APB
`timescale 1ns / 1ps

module tb_yuv_color_zone_counter;
  import yczc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PLAN_LEN     = 41;

  typedef enum logic {STEP_CFG, STEP_PAIR} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    reg_e        addr;
    logic [31:0] value;
    pix_t        pix;
    bit          typed;
    res_t        res;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  yczc_pix_if pix_bus ();
  yczc_res_if res_bus ();

  yuv_color_zone_counter DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_bus),
    .res_o   (res_bus)
  );

  // shadow of the configuration and the frame state
  logic [15:0]      luma_win_q  = RST_LUMA_WIN;
  logic [15:0]      u_win_q     = RST_U_WIN;
  logic [15:0]      v_win_q     = RST_V_WIN;
  logic [DIM_W-1:0] width_q     = RST_WIDTH;
  logic [DIM_W-1:0] height_q    = RST_HEIGHT;
  logic [1:0]       zone_mode_q = RST_MODE;
  logic [PCT_W-1:0] safe_pct_q  = RST_SAFE_PCT;
  logic [POS_W-1:0] col_q       = '0;
  logic [ROW_W-1:0] row_q       = '0;
  tally_t           tally_q     = '0;

  res_t        pending_frames_q [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned idle_odds      = 5;
  int unsigned stall_odds     = 4;
  bit          steady         = 1'b0;

  // windows are {max, min}; a full window is 16'hFF00
  plan_row_t plan [PLAN_LEN] = '{
    // reset setup: rotated half view skips the left half, so nothing counts
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'd100, 8'd90, 8'd120, 8'd90, 1'b1}, 1'b1,
      {25'd0, 25'd0, 25'd0, 25'd0, STEER_STRAIGHT}},
    '{STEP_CFG, REG_LUMA_WIN, 32'hFF00, '0, 1'b0, '0},
    '{STEP_CFG, REG_U_WIN,    32'hFF00, '0, 1'b0, '0},
    '{STEP_CFG, REG_V_WIN,    32'hFF00, '0, 1'b0, '0},
    '{STEP_CFG, REG_WIDTH,    32'd6,    '0, 1'b0, '0},
    '{STEP_CFG, REG_HEIGHT,   32'd1,    '0, 1'b0, '0},
    '{STEP_CFG, REG_MODE,     32'd0,    '0, 1'b0, '0},
    // one row of three pairs, all match: one third straight is under 40 percent
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1}, 1'b1,
      {25'd2, 25'd2, 25'd2, 25'd6, STEER_STRAIGHT}},
    // percentage above 100 always keeps straight
    '{STEP_CFG, REG_SAFE_PCT, 32'd127, '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h80, 8'h01, 8'h7F, 8'hFE, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h01, 8'h80, 8'hFE, 8'h7F, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1}, 1'b1,
      {25'd2, 25'd2, 25'd2, 25'd6, STEER_STRAIGHT}},
    // zero luma misses the left third, so left is strictly least
    '{STEP_CFG, REG_SAFE_PCT, 32'd0,     '0, 1'b0, '0},
    '{STEP_CFG, REG_LUMA_WIN, 32'hFF01,  '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h10, 8'h00, 8'h20, 8'h00, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h20, 8'h01, 8'h10, 8'hFF, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h33, 8'hCC, 8'hC3, 8'h3C, 1'b1}, 1'b1,
      {25'd0, 25'd2, 25'd2, 25'd4, STEER_LEFT}},
    // inverted chroma window matches nothing
    '{STEP_CFG, REG_U_WIN, 32'h00FF, '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h00, 8'h40, 8'h40, 8'h40, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'hFF, 8'h40, 8'h40, 8'h40, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h7F, 8'h40, 8'h40, 8'h40, 1'b1}, 1'b1,
      {25'd0, 25'd0, 25'd0, 25'd0, STEER_STRAIGHT}},
    // rotated, one pair per row, zones by row thirds
    '{STEP_CFG, REG_U_WIN,  32'hFF00, '0, 1'b0, '0},
    '{STEP_CFG, REG_WIDTH,  32'd2,    '0, 1'b0, '0},
    '{STEP_CFG, REG_HEIGHT, 32'd3,    '0, 1'b0, '0},
    '{STEP_CFG, REG_MODE,   32'd1,    '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h40, 8'h40, 8'h40, 8'h40, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h40, 8'h40, 8'h40, 8'h40, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h40, 8'h40, 8'h40, 8'h40, 1'b1}, 1'b1,
      {25'd2, 25'd2, 25'd2, 25'd6, STEER_RIGHT}},
    // rotated half view drops column 0
    '{STEP_CFG, REG_MODE, 32'd3, '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h50, 8'h60, 8'h70, 8'h80, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h50, 8'h60, 8'h70, 8'h80, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h50, 8'h60, 8'h70, 8'h80, 1'b1}, 1'b1,
      {25'd1, 25'd1, 25'd1, 25'd3, STEER_RIGHT}},
    // odd width: second pixel of the last pair lies past the row, bottom half dropped
    '{STEP_CFG, REG_MODE,   32'd2, '0, 1'b0, '0},
    '{STEP_CFG, REG_WIDTH,  32'd3, '0, 1'b0, '0},
    '{STEP_CFG, REG_HEIGHT, 32'd2, '0, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b0}, 1'b0, '0},
    '{STEP_PAIR, REG_LUMA_WIN, 32'd0, {8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b1}, 1'b1,
      {25'd1, 25'd1, 25'd2, 25'd4, STEER_RIGHT}}
  };

  int unsigned odd_widths [6]  = '{0, 1, 2, 4095, 4096, 8191};
  int unsigned odd_heights [4] = '{0, 1, 4096, 8191};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- frame count predictor ----------------

  function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t);
    return (t == TALLY_MAX) ? t : t + 1'b1;
  endfunction

  function automatic bit window_hit(input logic [15:0] win, input logic [7:0] val);
    return (val >= win[7:0]) && (val <= win[15:8]);
  endfunction

  task automatic score_pixel(input int unsigned x, input int unsigned y,
                             input logic [7:0] luma, input logic [7:0] u,
                             input logic [7:0] v);
    int unsigned coord;
    int unsigned third;
    bit          rotated;
    bit          half;
    rotated = zone_mode_q[0];
    half    = zone_mode_q[1];
    if (half && rotated && x < width_q / 2) return;
    if (half && !rotated && y >= height_q / 2) return;
    if (!(window_hit(luma_win_q, luma) && window_hit(u_win_q, u) &&
          window_hit(v_win_q, v))) return;
    coord = rotated ? y : x;
    third = rotated ? height_q / 3 : width_q / 3;
    if (coord < third) tally_q.left = bump(tally_q.left);
    else if (coord < 2 * third) tally_q.straight = bump(tally_q.straight);
    else tally_q.right = bump(tally_q.right);
    tally_q.total = bump(tally_q.total);
  endtask

  task automatic tally_pair(input pix_t p, output bit closed, output res_t r);
    int unsigned nxt;
    longint      share;
    longint      bar;
    steer_e      dir;
    score_pixel(col_q, row_q, p.luma_first, p.chroma_u, p.chroma_v);
    score_pixel(col_q + 1, row_q, p.luma_second, p.chroma_u, p.chroma_v);
    nxt = col_q + 2;
    if (nxt >= width_q || nxt >= MAX_WIDTH) begin
      col_q = '0;
      row_q = (int'(row_q) + 1 >= MAX_HEIGHT) ? '0 : row_q + 1'b1;
    end else begin
      col_q = POS_W'(nxt);
    end
    closed = p.frame_end;
    r = '0;
    if (closed) begin
      share = longint'(tally_q.straight) * 100;
      bar   = longint'(safe_pct_q) * longint'(tally_q.total);
      if (tally_q.total == '0 || share < bar) dir = STEER_STRAIGHT;
      else if (tally_q.left < tally_q.straight && tally_q.left < tally_q.right) dir = STEER_LEFT;
      else dir = STEER_RIGHT;
      r.left_count     = tally_q.left;
      r.straight_count = tally_q.straight;
      r.right_count    = tally_q.right;
      r.match_total    = tally_q.total;
      r.steer          = dir;
      tally_q = '0;
      col_q   = '0;
      row_q   = '0;
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [7:0] near_window(input logic [15:0] win);
    if (win[7:0] <= win[15:8] && $urandom_range(3, 0) != 0)
      return 8'($urandom_range(win[15:8], win[7:0]));
    return 8'($urandom);
  endfunction

  function automatic pix_t random_pair();
    pix_t p;
    p.chroma_u    = near_window(u_win_q);
    p.luma_first  = near_window(luma_win_q);
    p.chroma_v    = near_window(v_win_q);
    p.luma_second = near_window(luma_win_q);
    p.frame_end   = 1'b0;
    return p;
  endfunction

  function automatic logic [15:0] pick_window();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'($urandom_range(200, 0));
    hi = 8'($urandom_range(255, lo));
    case ($urandom_range(9, 0))
      0: return 16'hFF00;
      1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      4: return {lo, hi};  // min above max unless equal
      default: return {hi, lo};
    endcase
  endfunction

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LUMA_WIN: luma_win_q  = val[15:0];
      REG_U_WIN:    u_win_q     = val[15:0];
      REG_V_WIN:    v_win_q     = val[15:0];
      REG_WIDTH:    width_q     = val[DIM_W-1:0];
      REG_HEIGHT:   height_q    = val[DIM_W-1:0];
      REG_MODE:     zone_mode_q = val[1:0];
      REG_SAFE_PCT: safe_pct_q  = val[PCT_W-1:0];
      default: ;
    endcase
    // frame size updates reach the registered thirds behind the write; wait for them
    repeat (2) @(posedge clk_i);
  endtask

  // called on a rising edge; returns on the edge that takes the beat
  task automatic send_pair(input pix_t p, input bit typed, input res_t typed_res);
    bit   closed;
    res_t calc;
    if (!steady && idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.data  <= p;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    tally_pair(p, closed, calc);
    if (closed) pending_frames_q.push_back(typed ? typed_res : calc);
  endtask

  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (pending_frames_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_random_config();
    case ($urandom_range(7, 0))
      0: write_reg(REG_WIDTH, odd_widths[$urandom_range(5, 0)]);
      default: write_reg(REG_WIDTH, $urandom_range(24, 2));
    endcase
    case ($urandom_range(7, 0))
      0: write_reg(REG_HEIGHT, odd_heights[$urandom_range(3, 0)]);
      default: write_reg(REG_HEIGHT, $urandom_range(8, 1));
    endcase
    write_reg(REG_LUMA_WIN, pick_window());
    write_reg(REG_U_WIN, pick_window());
    write_reg(REG_V_WIN, pick_window());
    write_reg(REG_MODE, $urandom_range(3, 0));
    case ($urandom_range(7, 0))
      0: write_reg(REG_SAFE_PCT, 0);
      1: write_reg(REG_SAFE_PCT, 100);
      2: write_reg(REG_SAFE_PCT, 127);
      3: write_reg(REG_SAFE_PCT, $urandom_range(127, 101));
      default: write_reg(REG_SAFE_PCT, $urandom_range(100, 0));
    endcase
  endtask

  // ---------------- result checking ----------------

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_frames_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with none pending", results_seen));
      end else begin
        want = pending_frames_q.pop_front();
        compare_field("left_count", res_bus.data.left_count, want.left_count);
        compare_field("straight_count", res_bus.data.straight_count, want.straight_count);
        compare_field("right_count", res_bus.data.right_count, want.right_count);
        compare_field("match_total", res_bus.data.match_total, want.match_total);
        compare_field("steer", res_bus.data.steer, want.steer);
      end
      results_seen++;
    end
  end

  // result sink with bursts of back-pressure
  initial begin : result_sink
    res_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!steady && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin : stimulus
    int unsigned rand_pairs;
    int unsigned span;
    int unsigned row_pairs;
    bit          shaped;
    pix_t        px;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pix_bus.valid <= 1'b0;
    pix_bus.data  <= '0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        settle();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_pair(plan[i].pix, plan[i].typed, plan[i].res);
      end
    end

    rand_pairs = 0;
    while (rand_pairs < 1000) begin
      settle();
      write_random_config();
      case ($urandom_range(3, 0))
        0: idle_odds = 0;
        1: idle_odds = 3;
        2: idle_odds = 6;
        default: idle_odds = 10;
      endcase
      stall_odds = $urandom_range(1, 0) ? 3 : 8;
      row_pairs = (width_q >= MAX_WIDTH) ? MAX_WIDTH / 2 :
                  (width_q <= 2) ? 1 : (width_q + 1) / 2;
      repeat ($urandom_range(6, 2)) begin
        // most frames are whole; the rest are cut short or run on
        shaped = ($urandom_range(4, 0) != 0);
        span = row_pairs * ((height_q == 0) ? 1 : height_q);
        if (!shaped || span > 96) span = $urandom_range(40, 1);
        for (int i = 0; i < span; i++) begin
          px = random_pair();
          px.frame_end = (i == span - 1) && (shaped || $urandom_range(3, 0) != 0);
          if (!shaped && $urandom_range(15, 0) == 0) px.frame_end = 1'b1;
          send_pair(px, 1'b0, '0);
          rand_pairs++;
          if (rand_pairs >= 850) steady = 1'b1;
        end
      end
    end

    settle();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
